@@ rtl/grw_pkg.sv @@
`timescale 1ns / 1ps

package grw_pkg;

	// default geometry
	localparam int MAP_WIDTH_DEF  = 8;
	localparam int MAP_HEIGHT_DEF = 8;
	localparam int MAX_STEPS_DEF  = 8;

	// one cell is 64 map units of Q.8, i.e. 2^14
	localparam int CELL_SHIFT  = 14;
	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = 6;
	localparam int IDX_W       = 6;
	localparam int MP_W        = 12;
	localparam int VAL_W       = 8;

	localparam int ANG_W       = 12;
	localparam int ANGLE_STEPS = 4096;
	localparam int ANG_QUARTER = ANGLE_STEPS / 4;
	localparam int ANG_HALF    = ANGLE_STEPS / 2;
	localparam int ANG_3QUART  = 3 * ANGLE_STEPS / 4;

	localparam int COORD_W = 17;
	localparam int OUT_W   = 24;

	// datapath widths
	localparam int CS_W    = 34;
	localparam int DL_W    = 16;
	localparam int PROD_W  = 2 * CS_W;
	localparam int QUO_W   = 50;
	localparam int POS_W   = 56;
	localparam int SQ_W    = 64;
	localparam int ROOT_W  = SQ_W / 2;
	localparam int SPAN_W  = 32;

	localparam int CORDIC_ITERS = 28;
	localparam int ITER_W       = 5;
	localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;

	// command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_CAST  = 1'b1;

	// register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_VIEWER_X = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_VIEWER_Y = 1'b1;

	// arctangent per CORDIC iteration, in units of 2^-32 turn
	function automatic logic signed [CS_W-1:0] turn_atan(input logic [ITER_W-1:0] idx);
		logic signed [CS_W-1:0] r;
		unique case (idx)
			5'd0:  r = 34'sd536870912;
			5'd1:  r = 34'sd316933406;
			5'd2:  r = 34'sd167458907;
			5'd3:  r = 34'sd85004756;
			5'd4:  r = 34'sd42667331;
			5'd5:  r = 34'sd21354465;
			5'd6:  r = 34'sd10679838;
			5'd7:  r = 34'sd5340245;
			5'd8:  r = 34'sd2670163;
			5'd9:  r = 34'sd1335087;
			5'd10: r = 34'sd667544;
			5'd11: r = 34'sd333772;
			5'd12: r = 34'sd166886;
			5'd13: r = 34'sd83443;
			5'd14: r = 34'sd41722;
			5'd15: r = 34'sd20861;
			5'd16: r = 34'sd10430;
			5'd17: r = 34'sd5215;
			5'd18: r = 34'sd2608;
			5'd19: r = 34'sd1304;
			5'd20: r = 34'sd652;
			5'd21: r = 34'sd326;
			5'd22: r = 34'sd163;
			5'd23: r = 34'sd81;
			5'd24: r = 34'sd41;
			5'd25: r = 34'sd20;
			5'd26: r = 34'sd10;
			5'd27: r = 34'sd5;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/grw_ram.sv @@
`timescale 1ns / 1ps

module grw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/grw_div.sv @@
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle, truncates toward zero
module grw_div #(
	parameter int NUM_W = 50,
	parameter int DEN_W = 34
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [DEN_W-1:0] den,
	output logic signed [NUM_W-1:0] quo,
	output logic                    done
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             run_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] nq_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] dmag_q;
	logic             neg_q;

	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W:0]   rem_n;

	always_comb begin
		trial = {rem_q, nq_q[NUM_W-1]};
		ge    = (trial >= {1'b0, dmag_q});
		rem_n = ge ? (trial - {1'b0, dmag_q}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				nq_q   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
				dmag_q <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
				neg_q  <= num[NUM_W-1] ^ den[DEN_W-1];
				rem_q  <= '0;
				cnt_q  <= '0;
				run_q  <= 1'b1;
			end else if (run_q) begin
				nq_q  <= {nq_q[NUM_W-2:0], ge};
				rem_q <= rem_n[DEN_W-1:0];
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	assign quo = neg_q ? -$signed(nq_q) : $signed(nq_q);

endmodule

@@ rtl/grw_sqrt.sv @@
`timescale 1ns / 1ps

// bitwise integer square root, two radicand bits per cycle
module grw_sqrt #(
	parameter int RAD_W = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [RAD_W-1:0]     rad,
	output logic [RAD_W/2-1:0]   root,
	output logic                 done
);

	logic             run_q;
	logic [RAD_W-1:0] n_q;
	logic [RAD_W-1:0] res_q;
	logic [RAD_W-1:0] bit_q;
	logic [RAD_W-1:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				n_q   <= rad;
				res_q <= '0;
				bit_q <= RAD_W'(1) << (RAD_W - 2);
				run_q <= 1'b1;
			end else if (run_q) begin
				if (n_q >= trial) begin
					n_q   <= n_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	assign root = res_q[RAD_W/2-1:0];

endmodule

@@ rtl/grid_ray_wall_hit.sv @@
`timescale 1ns / 1ps
// Map write: no result, and the block stays idle; the next command may follow in the next cycle.
// Ray cast: the CORDIC rotations, a sign fix and the side selects, then per searched side
// the setup and product steps, the offset and step divisions in the shared serial divider,
// up to MAX_STEPS map reads (registered read) and the squares and the 32-step root, plus
// a final step to finish; a side that is parallel is skipped.
// One ray at a time; done pulses for one cycle as busy drops and cannot be stalled.
// Reset clears the map (valid bits), the held textures and the viewer.

module grid_ray_wall_hit #(
	parameter int MAP_WIDTH  = grw_pkg::MAP_WIDTH_DEF,
	parameter int MAP_HEIGHT = grw_pkg::MAP_HEIGHT_DEF,
	parameter int MAX_STEPS  = grw_pkg::MAX_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// command side
	input  logic                start,
	output logic                busy,
	input  logic                command,
	input  logic [5:0]          cell_index,
	input  logic [7:0]          cell_value,
	input  logic [11:0]         ray_angle,
	// configuration
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [16:0]         cfg_data,
	// result
	output logic                done,
	output logic signed [23:0]  hit_x,
	output logic signed [23:0]  hit_y,
	output logic [23:0]         hit_distance,
	output logic [7:0]          wall_texture,
	output logic                vertical_side
);

	localparam int CS_W       = grw_pkg::CS_W;
	localparam int DL_W       = grw_pkg::DL_W;
	localparam int PROD_W     = grw_pkg::PROD_W;
	localparam int QUO_W      = grw_pkg::QUO_W;
	localparam int POS_W      = grw_pkg::POS_W;
	localparam int SQ_W       = grw_pkg::SQ_W;
	localparam int ROOT_W     = grw_pkg::ROOT_W;
	localparam int SPAN_W     = grw_pkg::SPAN_W;
	localparam int ITER_W     = grw_pkg::ITER_W;
	localparam int ANG_W      = grw_pkg::ANG_W;
	localparam int COORD_W    = grw_pkg::COORD_W;
	localparam int OUT_W      = grw_pkg::OUT_W;
	localparam int VAL_W      = grw_pkg::VAL_W;
	localparam int ADDR_W     = grw_pkg::ADDR_W;
	localparam int IDX_W      = grw_pkg::IDX_W;
	localparam int MP_W       = grw_pkg::MP_W;
	localparam int CELL_SHIFT = grw_pkg::CELL_SHIFT;
	localparam int STEP_W     = $clog2(MAX_STEPS + 1);

	localparam logic signed [POS_W-1:0] CELL_Q = POS_W'(1) << CELL_SHIFT;
	localparam logic signed [POS_W-1:0] X_LIM  = POS_W'(MAP_WIDTH) << CELL_SHIFT;
	localparam logic signed [POS_W-1:0] Y_LIM  = POS_W'(MAP_HEIGHT) << CELL_SHIFT;
	localparam logic signed [CS_W-1:0]  Z_QUART = CS_W'(1) << 30;
	localparam logic signed [CS_W-1:0]  Z_HALF  = CS_W'(1) << 31;

	typedef enum logic [4:0] {
		S_IDLE, S_CORD, S_CORD_FIN, S_HSEL, S_VSEL, S_SETUP, S_MUL_W,
		S_DIV1_GO, S_DIV1_W, S_DIV2_GO, S_DIV2_W, S_PROBE, S_RD_W,
		S_DIST_A, S_DIST_B, S_DIST_C, S_DIST_D, S_SQRT_W, S_FIN
	} state_t;

	state_t state_q;

	// viewer and current ray
	logic [COORD_W-1:0]       px_q, py_q;
	logic [ANG_W-1:0]         angle_q;
	// CORDIC
	logic signed [CS_W-1:0]   cx_q, cy_q, cz_q;
	logic                     flip_q;
	logic [ITER_W-1:0]        it_q;
	logic signed [CS_W-1:0]   c_q, s_q;
	logic                     hpar_q, vpar_q;
	// side walk: f is the axis that crosses grid lines, o the other one
	logic                     side_q;
	logic signed [POS_W-1:0]  f_q, o_q, fstep_q, ostep_q;
	logic [STEP_W-1:0]        step_q;
	logic                     oob_q, vld_rd_q;
	logic [VAL_W-1:0]         h_tex_q, v_tex_q;
	logic signed [POS_W-1:0]  hx_q, hy_q, vx_q, vy_q;
	logic [ROOT_W-1:0]        hd_q, vd_q;
	// shared multiplier
	logic signed [CS_W-1:0]   mul_a_q, mul_b_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [SQ_W-1:0]          sqa_q;
	logic [SPAN_W-1:0]        b_q;
	// map valid bits
	logic [grw_pkg::STORE_DEPTH-1:0] valid_q;

	// combinational
	logic signed [POS_W-1:0]  px_w, py_w, pf_w, po_w, line_w, start_f, dl_w, fstep_w;
	logic signed [DL_W-1:0]   dl;
	logic signed [CS_W-1:0]   trig_num, trig_den;
	logic                     dir_neg;
	logic signed [CS_W-1:0]   xs, ys, nx, ny, nz, atan_v;
	logic signed [CS_W-1:0]   z0, z_init;
	logic                     flip_init;
	logic signed [POS_W-1:0]  x_w, y_w;
	logic                     in_map;
	logic [IDX_W-1:0]         col, row;
	logic [MP_W-1:0]          mp;
	logic                     mp_oob;
	logic [VAL_W-1:0]         rdata, rd_val;
	logic                     ram_we;
	logic                     hpar, vpar, pick_v;
	logic                     div_start, div_done;
	logic signed [QUO_W-1:0]  div_num, quo;
	logic signed [CS_W-1:0]   div_den;
	logic                     sq_start, sq_done;
	logic [ROOT_W-1:0]        root;
	logic [STEP_W-1:0]        step_n;

	function automatic logic [SPAN_W-1:0] span(input logic signed [POS_W-1:0] d);
		logic [POS_W-1:0] m;
		m = d[POS_W-1] ? POS_W'(-d) : POS_W'(d);
		if (m > (POS_W'(1) << 31)) begin
			return SPAN_W'(1) << 31;
		end
		return m[SPAN_W-1:0];
	endfunction

	function automatic logic [OUT_W-1:0] sat24(input logic signed [POS_W-1:0] v);
		if (v > POS_W'(24'sh7FFFFF)) begin
			return 24'h7FFFFF;
		end
		if (v < -(POS_W'(1) << 23)) begin
			return 24'h800000;
		end
		return v[OUT_W-1:0];
	endfunction

	assign busy = (state_q != S_IDLE);

	// geometry of the side under work
	always_comb begin
		px_w     = POS_W'(px_q);
		py_w     = POS_W'(py_q);
		pf_w     = side_q ? px_w : py_w;
		po_w     = side_q ? py_w : px_w;
		trig_num = side_q ? s_q : c_q;
		trig_den = side_q ? c_q : s_q;
		dir_neg  = side_q ? (angle_q > ANG_W'(grw_pkg::ANG_QUARTER) &&
		                     angle_q < ANG_W'(grw_pkg::ANG_3QUART))
		                  : (angle_q > ANG_W'(grw_pkg::ANG_HALF));
		line_w   = pf_w & ~(CELL_Q - POS_W'(1));
		// going up or left: start just before the line so the probe lands in the far cell
		start_f  = dir_neg ? (line_w - POS_W'(1)) : (line_w + CELL_Q);
		dl_w     = start_f - pf_w;
		dl       = dl_w[DL_W-1:0];
		fstep_w  = dir_neg ? -CELL_Q : CELL_Q;
	end

	// CORDIC rotation step and start angle folding
	always_comb begin
		atan_v = grw_pkg::turn_atan(it_q);
		xs     = cx_q >>> it_q;
		ys     = cy_q >>> it_q;
		if (!cz_q[CS_W-1]) begin
			nx = cx_q - ys;
			ny = cy_q + xs;
			nz = cz_q - atan_v;
		end else begin
			nx = cx_q + ys;
			ny = cy_q - xs;
			nz = cz_q + atan_v;
		end
		z0 = CS_W'($signed(32'(ray_angle) << (32 - ANG_W)));
		flip_init = 1'b0;
		z_init    = z0;
		if (z0 > Z_QUART) begin
			z_init    = z0 - Z_HALF;
			flip_init = 1'b1;
		end else if (z0 < -Z_QUART) begin
			z_init    = z0 + Z_HALF;
			flip_init = 1'b1;
		end
	end

	// map probe address
	always_comb begin
		x_w    = side_q ? f_q : o_q;
		y_w    = side_q ? o_q : f_q;
		in_map = !x_w[POS_W-1] && !y_w[POS_W-1] && (x_w < X_LIM) && (y_w < Y_LIM);
		col    = x_w[CELL_SHIFT+IDX_W-1:CELL_SHIFT];
		row    = y_w[CELL_SHIFT+IDX_W-1:CELL_SHIFT];
		mp     = MP_W'(row) * MP_W'(MAP_WIDTH) + MP_W'(col);
		mp_oob = (mp >= MP_W'(grw_pkg::STORE_DEPTH));
		// never written, or beyond the store: reads empty
		rd_val = (oob_q || !vld_rd_q) ? '0 : rdata;
		step_n = step_q + 1'b1;
	end

	always_comb begin
		hpar = (angle_q == '0) || (angle_q == ANG_W'(grw_pkg::ANG_HALF)) || (s_q == '0);
		vpar = (angle_q == ANG_W'(grw_pkg::ANG_QUARTER)) ||
		       (angle_q == ANG_W'(grw_pkg::ANG_3QUART)) || (c_q == '0);
		// equal distances go to the vertical side
		if (hpar_q) begin
			pick_v = 1'b1;
		end else if (vpar_q) begin
			pick_v = 1'b0;
		end else begin
			pick_v = !(hd_q < vd_q);
		end
	end

	assign ram_we    = start && !busy && (command == grw_pkg::CMD_WRITE);
	assign div_start = (state_q == S_DIV1_GO) || (state_q == S_DIV2_GO);
	assign div_num   = prod_q[QUO_W-1:0];
	assign div_den   = trig_den;
	assign sq_start  = (state_q == S_DIST_D);

	grw_ram #(
		.WIDTH (VAL_W),
		.DEPTH (grw_pkg::STORE_DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cell_index),
		.wdata (cell_value),
		.raddr (mp[ADDR_W-1:0]),
		.rdata (rdata)
	);

	grw_div #(
		.NUM_W (QUO_W),
		.DEN_W (CS_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (quo),
		.done   (div_done)
	);

	grw_sqrt #(
		.RAD_W (SQ_W)
	) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.rad    (sqa_q + prod_q[SQ_W-1:0]),
		.root   (root),
		.done   (sq_done)
	);

	// multiplier, registered every cycle
	always_ff @(posedge clk) begin
		prod_q <= mul_a_q * mul_b_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			px_q    <= '0;
			py_q    <= '0;
			h_tex_q <= '0;
			v_tex_q <= '0;
			valid_q <= '0;
			step_q  <= '0;
			side_q  <= 1'b0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;

			if (cfg_we) begin
				unique case (cfg_index)
					grw_pkg::REG_VIEWER_X: px_q <= cfg_data;
					grw_pkg::REG_VIEWER_Y: py_q <= cfg_data;
					default: ;
				endcase
			end

			if (ram_we) begin
				valid_q[cell_index] <= 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (start && command == grw_pkg::CMD_CAST) begin
						angle_q <= ray_angle;
						cx_q    <= grw_pkg::CORDIC_GAIN;
						cy_q    <= '0;
						cz_q    <= z_init;
						flip_q  <= flip_init;
						it_q    <= '0;
						state_q <= S_CORD;
					end
				end
				S_CORD: begin
					cx_q <= nx;
					cy_q <= ny;
					cz_q <= nz;
					it_q <= it_q + 1'b1;
					if (it_q == ITER_W'(grw_pkg::CORDIC_ITERS - 1)) begin
						state_q <= S_CORD_FIN;
					end
				end
				S_CORD_FIN: begin
					c_q     <= flip_q ? -cx_q : cx_q;
					s_q     <= flip_q ? -cy_q : cy_q;
					state_q <= S_HSEL;
				end
				S_HSEL: begin
					hpar_q <= hpar;
					hx_q   <= px_w;
					hy_q   <= py_w;
					hd_q   <= '0;
					if (hpar) begin
						state_q <= S_VSEL;
					end else begin
						side_q  <= 1'b0;
						state_q <= S_SETUP;
					end
				end
				S_VSEL: begin
					vpar_q <= vpar;
					vx_q   <= px_w;
					vy_q   <= py_w;
					vd_q   <= '0;
					if (vpar) begin
						state_q <= S_FIN;
					end else begin
						side_q  <= 1'b1;
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					f_q     <= start_f;
					fstep_q <= fstep_w;
					step_q  <= '0;
					mul_a_q <= CS_W'(dl);
					mul_b_q <= trig_num;
					state_q <= S_MUL_W;
				end
				S_MUL_W: begin
					state_q <= S_DIV1_GO;
				end
				S_DIV1_GO: begin
					// offset to first crossing is in prod_q; queue the per-step product
					mul_a_q <= fstep_w[CS_W-1:0];
					state_q <= S_DIV1_W;
				end
				S_DIV1_W: begin
					if (div_done) begin
						o_q     <= po_w + POS_W'(quo);
						state_q <= S_DIV2_GO;
					end
				end
				S_DIV2_GO: begin
					state_q <= S_DIV2_W;
				end
				S_DIV2_W: begin
					if (div_done) begin
						ostep_q <= POS_W'(quo);
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					oob_q    <= mp_oob;
					vld_rd_q <= valid_q[mp[ADDR_W-1:0]];
					if (in_map) begin
						state_q <= S_RD_W;
					end else begin
						state_q <= S_DIST_A;
					end
				end
				S_RD_W: begin
					if (rd_val != '0) begin
						if (side_q) begin
							v_tex_q <= rd_val - 1'b1;
						end else begin
							h_tex_q <= rd_val - 1'b1;
						end
						state_q <= S_DIST_A;
					end else begin
						f_q    <= f_q + fstep_q;
						o_q    <= o_q + ostep_q;
						step_q <= step_n;
						if (step_n == STEP_W'(MAX_STEPS)) begin
							state_q <= S_DIST_A;
						end else begin
							state_q <= S_PROBE;
						end
					end
				end
				S_DIST_A: begin
					if (side_q) begin
						vx_q <= x_w;
						vy_q <= y_w;
					end else begin
						hx_q <= x_w;
						hy_q <= y_w;
					end
					mul_a_q <= CS_W'(span(x_w - px_w));
					mul_b_q <= CS_W'(span(x_w - px_w));
					b_q     <= span(y_w - py_w);
					state_q <= S_DIST_B;
				end
				S_DIST_B: begin
					mul_a_q <= CS_W'(b_q);
					mul_b_q <= CS_W'(b_q);
					state_q <= S_DIST_C;
				end
				S_DIST_C: begin
					sqa_q   <= prod_q[SQ_W-1:0];
					state_q <= S_DIST_D;
				end
				S_DIST_D: begin
					state_q <= S_SQRT_W;
				end
				S_SQRT_W: begin
					if (sq_done) begin
						if (side_q) begin
							vd_q    <= root;
							state_q <= S_FIN;
						end else begin
							hd_q    <= root;
							state_q <= S_VSEL;
						end
					end
				end
				S_FIN: begin
					done          <= 1'b1;
					hit_x         <= pick_v ? sat24(vx_q) : sat24(hx_q);
					hit_y         <= pick_v ? sat24(vy_q) : sat24(hy_q);
					hit_distance  <= (pick_v ? (vd_q > ROOT_W'(24'hFFFFFF))
					                         : (hd_q > ROOT_W'(24'hFFFFFF))) ? 24'hFFFFFF
					                 : (pick_v ? vd_q[OUT_W-1:0] : hd_q[OUT_W-1:0]);
					wall_texture  <= pick_v ? v_tex_q : h_tex_q;
					vertical_side <= pick_v;
					state_q       <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a result transaction only follows the final state and leaves the block free
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result shown while busy");
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_FIN))
		else $error("result without finishing a ray");
	a_steps: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_W'(MAX_STEPS))
		else $error("walk ran past its step limit");
	a_div_den: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (div_den != '0))
		else $error("division by zero slope");
	a_rd_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD_W) |-> $past(state_q == S_PROBE))
		else $error("map data checked without a read");

endmodule

@@ tb/grid_ray_wall_hit_tb.sv @@
`timescale 1ns / 1ps

module grid_ray_wall_hit_tb;

	localparam longint CELL_Q   = 64'sd16384;   // one cell in Q.8
	localparam int     GRID_W   = 8;
	localparam int     GRID_H   = 8;
	localparam int     PROBES   = 8;            // steps per side
	localparam int     N_ITEMS  = 1000;
	localparam int     WD_LIMIT = 4000;         // generous margin over the longest cast
	localparam int     SETTLE   = 20;           // covers the map write

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic [23:0]        hit_dist;
		logic [7:0]         tex;
		logic               vside;
	} wall_hit_t;

	// Behavioural copy of the ray caster plus the queue of hits still owed by the DUT.
	class wall_hit_tracker;
		byte unsigned cells [64];
		byte unsigned horiz_tex, vert_tex;
		longint       eye_x, eye_y;
		wall_hit_t    pending_hits [$];
		int           mismatches;

		function new();
			foreach (cells[i]) cells[i] = 0;
			horiz_tex = 0;
			vert_tex = 0;
			eye_x = 0;
			eye_y = 0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [grw_pkg::CFG_IDX_W-1:0] idx, logic [16:0] val);
			if (idx == grw_pkg::REG_VIEWER_X)
				eye_x = longint'(val);
			else
				eye_y = longint'(val);
		endfunction

		// 28 rotations in Q30, floor shifts throughout
		function void rotate(longint phase, output longint cs, output longint sn);
			longint z, x, y, t, atn [28];
			bit flip;
			atn = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
				10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
				41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};
			z = phase;
			x = 652032874;
			y = 0;
			flip = 0;
			if (z >= (64'sd1 << 31))
				z -= (64'sd1 << 32);
			if (z > (64'sd1 << 30)) begin
				z -= (64'sd1 << 31);
				flip = 1;
			end else if (z < -(64'sd1 << 30)) begin
				z += (64'sd1 << 31);
				flip = 1;
			end
			for (int i = 0; i < 28; i++) begin
				if (z >= 0) begin
					t = x - (y >>> i);
					y = y + (x >>> i);
					z -= atn[i];
				end else begin
					t = x + (y >>> i);
					y = y - (x >>> i);
					z += atn[i];
				end
				x = t;
			end
			cs = flip ? -x : x;
			sn = flip ? -y : y;
		endfunction

		// -1 off the map, else cell content
		function int cell_at(longint rx, longint ry);
			if (rx < 0 || ry < 0 || rx >= GRID_W * CELL_Q || ry >= GRID_H * CELL_Q)
				return -1;
			return int'(cells[(ry / CELL_Q) * GRID_W + rx / CELL_Q]);
		endfunction

		function void march(longint rx, longint ry, longint xo, longint yo, bit vert,
				output longint ex, output longint ey);
			int v;
			for (int k = 0; k < PROBES; k++) begin
				v = cell_at(rx, ry);
				if (v < 0)
					break;
				if (v > 0) begin
					if (vert)
						vert_tex = 8'(v - 1);
					else
						horiz_tex = 8'(v - 1);
					break;
				end
				rx += xo;
				ry += yo;
			end
			ex = rx;
			ey = ry;
		endfunction

		function longint unsigned euclid(longint dx, longint dy);
			longint unsigned a, b, n, res, bt;
			a = (dx < 0) ? -dx : dx;
			b = (dy < 0) ? -dy : dy;
			if (a > (64'd1 << 31)) a = 64'd1 << 31;
			if (b > (64'd1 << 31)) b = 64'd1 << 31;
			n = a * a + b * b;
			res = 0;
			bt = 64'd1 << 62;
			while (bt > n)
				bt >>= 2;
			while (bt != 0) begin
				if (n >= res + bt) begin
					n -= res + bt;
					res = (res >> 1) + bt;
				end else begin
					res >>= 1;
				end
				bt >>= 2;
			end
			return res;
		endfunction

		function logic [23:0] clip24(longint v);
			if (v > 8388607) v = 8388607;
			if (v < -8388608) v = -8388608;
			return v[23:0];
		endfunction

		function void note_command(logic cmd, logic [5:0] idx, logic [7:0] val,
				logic [11:0] ang);
			longint a, c, s, line, rx, ry, xo, yo, hx, hy, vx, vy;
			longint unsigned hd, vd;
			bit hpar, vpar, pick_v;
			wall_hit_t h;
			if (cmd == grw_pkg::CMD_WRITE) begin
				cells[idx] = val;
				return;
			end
			a = longint'(ang);
			hx = eye_x; hy = eye_y; vx = eye_x; vy = eye_y;
			hd = 0; vd = 0;
			rotate((a << 32) / grw_pkg::ANGLE_STEPS, c, s);

			hpar = (a == 0 || a == grw_pkg::ANG_HALF || s == 0);
			if (!hpar) begin
				line = (eye_y / CELL_Q) * CELL_Q;
				if (a > grw_pkg::ANG_HALF) begin
					ry = line - 1;     // just above the line, so the next cell up is probed
					yo = -CELL_Q;
				end else begin
					ry = line + CELL_Q;
					yo = CELL_Q;
				end
				rx = eye_x + ((ry - eye_y) * c) / s;
				xo = (yo * c) / s;
				march(rx, ry, xo, yo, 0, hx, hy);
				hd = euclid(hx - eye_x, hy - eye_y);
			end

			vpar = (a == grw_pkg::ANG_QUARTER || a == grw_pkg::ANG_3QUART || c == 0);
			if (!vpar) begin
				line = (eye_x / CELL_Q) * CELL_Q;
				if (a > grw_pkg::ANG_QUARTER && a < grw_pkg::ANG_3QUART) begin
					rx = line - 1;
					xo = -CELL_Q;
				end else begin
					rx = line + CELL_Q;
					xo = CELL_Q;
				end
				ry = eye_y + ((rx - eye_x) * s) / c;
				yo = (xo * s) / c;
				march(rx, ry, xo, yo, 1, vx, vy);
				vd = euclid(vx - eye_x, vy - eye_y);
			end

			if (hpar)
				pick_v = 1;
			else if (vpar)
				pick_v = 0;
			else
				pick_v = !(hd < vd);   // a tie goes to the vertical side

			h.x        = clip24(pick_v ? vx : hx);
			h.y        = clip24(pick_v ? vy : hy);
			h.hit_dist = (pick_v ? vd : hd) > 64'hFFFFFF ? 24'hFFFFFF
			             : 24'(pick_v ? vd : hd);
			h.tex      = pick_v ? vert_tex : horiz_tex;
			h.vside    = pick_v;
			pending_hits.push_back(h);
		endfunction

		function void check_hit(wall_hit_t got);
			wall_hit_t exp;
			if (pending_hits.size() == 0) begin
				$display("%0t: unexpected hit x=%0d y=%0d", $time, got.x, got.y);
				mismatches++;
				return;
			end
			exp = pending_hits.pop_front();
			if (got.x !== exp.x) begin
				$display("%0t: hit_x exp %0d got %0d", $time, exp.x, got.x);
				mismatches++;
			end
			if (got.y !== exp.y) begin
				$display("%0t: hit_y exp %0d got %0d", $time, exp.y, got.y);
				mismatches++;
			end
			if (got.hit_dist !== exp.hit_dist) begin
				$display("%0t: hit_distance exp %0d got %0d", $time, exp.hit_dist,
					got.hit_dist);
				mismatches++;
			end
			if (got.tex !== exp.tex) begin
				$display("%0t: wall_texture exp %0d got %0d", $time, exp.tex, got.tex);
				mismatches++;
			end
			if (got.vside !== exp.vside) begin
				$display("%0t: vertical_side exp %0d got %0d", $time, exp.vside, got.vside);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               start = 0;
	logic               busy;
	logic               command = grw_pkg::CMD_WRITE;
	logic [5:0]         cell_index = '0;
	logic [7:0]         cell_value = '0;
	logic [11:0]        ray_angle = '0;
	logic               cfg_we = 0;
	logic [0:0]         cfg_index = '0;
	logic [16:0]        cfg_data = '0;
	logic               done;
	logic signed [23:0] hit_x, hit_y;
	logic [23:0]        hit_distance;
	logic [7:0]         wall_texture;
	logic               vertical_side;

	wall_hit_tracker tracker = new();
	int              quiet_cycles = 0;

	grid_ray_wall_hit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.cell_index    (cell_index),
		.cell_value    (cell_value),
		.ray_angle     (ray_angle),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.done          (done),
		.hit_x         (hit_x),
		.hit_y         (hit_y),
		.hit_distance  (hit_distance),
		.wall_texture  (wall_texture),
		.vertical_side (vertical_side)
	);

	always #10 clk = ~clk;

	// Result side: strobe is one cycle wide and cannot be held off.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			tracker.check_hit('{hit_x, hit_y, hit_distance, wall_texture, vertical_side});
	end

	// Watchdog: any transaction or register write keeps it quiet.
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("grid_ray_wall_hit: mismatch");
			$finish;
		end
	end

	// Presents one transaction and returns on the edge that takes it; start stays high
	// so that back-to-back transactions need no extra edge.
	task automatic issue(logic cmd, logic [5:0] idx, logic [7:0] val, logic [11:0] ang);
		start      <= 1'b1;
		command    <= cmd;
		cell_index <= idx;
		cell_value <= val;
		ray_angle  <= ang;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		tracker.note_command(cmd, idx, val, ang);
	endtask

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Sender holds off until every owed hit is back, then lets the block settle.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (tracker.pending_hits.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic place_viewer(logic [16:0] px, logic [16:0] py);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= grw_pkg::REG_VIEWER_X;
		cfg_data  <= px;
		@(posedge clk);
		tracker.set_reg(grw_pkg::REG_VIEWER_X, px);
		cfg_index <= grw_pkg::REG_VIEWER_Y;
		cfg_data  <= py;
		@(posedge clk);
		tracker.set_reg(grw_pkg::REG_VIEWER_Y, py);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] random_cell();
		if ($urandom_range(0, 99) < 55)
			return 8'd0;
		if ($urandom_range(0, 9) == 0)
			return 8'd255;
		return 8'($urandom_range(1, 255));
	endfunction

	function automatic logic [11:0] random_angle();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 12'(grw_pkg::ANG_QUARTER * $urandom_range(0, 3));   // axis-parallel rays
		if (r == 1)
			return 12'(grw_pkg::ANG_QUARTER * $urandom_range(0, 3) + $urandom_range(0, 2) - 1);
		return 12'($urandom_range(0, grw_pkg::ANGLE_STEPS - 1));
	endfunction

	initial begin
		logic [16:0] vx_set [6];
		logic [16:0] vy_set [6];
		logic [11:0] axis_angles [10];
		int          n_done;

		vx_set = '{17'd0, 17'd131071, 17'd0, 17'd131071, 17'd70000, 17'd40000};
		vy_set = '{17'd0, 17'd131071, 17'd131071, 17'd0, 17'd60000, 17'd90000};
		axis_angles = '{12'd0, 12'd1, 12'd1023, 12'd1024, 12'd1025, 12'd2048,
			12'd2049, 12'd3072, 12'd3073, 12'd4095};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty map from the origin, then walls at the extremes of the fields.
		issue(grw_pkg::CMD_CAST, 6'd0, 8'd0, 12'd0);
		issue(grw_pkg::CMD_CAST, 6'd0, 8'd0, 12'd512);
		issue(grw_pkg::CMD_WRITE, 6'd0, 8'd255, 12'd0);      // corner cell is a wall too
		issue(grw_pkg::CMD_WRITE, 6'd63, 8'd1, 12'd4095);
		issue(grw_pkg::CMD_WRITE, 6'd9, 8'd128, 12'd0);
		place_viewer(17'd24576, 17'd24576);                  // middle of cell (1,1)
		foreach (axis_angles[i])
			issue(grw_pkg::CMD_CAST, 6'd0, 8'd0, axis_angles[i]);
		issue(grw_pkg::CMD_WRITE, 6'd9, 8'd0, 12'd0);
		issue(grw_pkg::CMD_CAST, 6'd0, 8'd0, 12'd2560);
		issue(grw_pkg::CMD_CAST, 6'd0, 8'd0, 12'd3584);

		// Random: several viewer positions, each with a fresh map and a mix of writes and casts.
		n_done = 0;
		for (int ph = 0; ph < 6; ph++) begin
			place_viewer(ph < 4 ? vx_set[ph] : 17'($urandom_range(0, 131071)),
				ph < 4 ? vy_set[ph] : 17'($urandom_range(0, 131071)));
			for (int c = 0; c < 64; c++)
				issue(grw_pkg::CMD_WRITE, c[5:0], random_cell(), 12'($urandom));
			for (int k = 0; k < (N_ITEMS - 6 * 64) / 6; k++) begin
				if ($urandom_range(0, 99) < 25)
					issue(grw_pkg::CMD_WRITE, 6'($urandom), random_cell(), 12'($urandom));
				else
					issue(grw_pkg::CMD_CAST, 6'($urandom), 8'($urandom), random_angle());
				n_done++;
				// phase 2 runs with no gaps at all
				if (ph != 2 && $urandom_range(0, 99) < 12)
					pause($urandom_range(1, 6));
			end
		end

		drain();
		if (tracker.mismatches == 0)
			$display("grid_ray_wall_hit: match");
		else
			$display("grid_ray_wall_hit: mismatch");
		$finish;
	end

endmodule

@@ files.f @@
rtl/grw_pkg.sv
rtl/grw_ram.sv
rtl/grw_div.sv
rtl/grw_sqrt.sv
rtl/grid_ray_wall_hit.sv
tb/grid_ray_wall_hit_tb.sv
